// File: hdl/rwg_pkg.sv
// ----------------------------------------------------------------------------
// rwg_pkg: shared types and constants of the reference waveform generator
// Register codes, waveform codes, configuration bundle, saturation and the
// elaboration-time sine table entry generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rwg_pkg;

	localparam int CFG_DATA_W = 25;
	localparam int SAMPLE_W   = 16;
	localparam int PHASE_OUT_W = 24;
	localparam int ROM_W      = 18;   // Q16 sine, -65536..65536

	typedef enum logic [2:0] {
		REG_PHASE_STEP = 3'd0,
		REG_DUTY       = 3'd1,
		REG_AMPLITUDE  = 3'd2,
		REG_OFFSET     = 3'd3,
		REG_RISE_STEP  = 3'd4,
		REG_FALL_STEP  = 3'd5,
		REG_WAVEFORM   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		WF_STEP  = 3'd0,
		WF_SLEW  = 3'd1,
		WF_CONST = 3'd2,
		WF_SINE  = 3'd3,
		WF_ZERO  = 3'd4
	} wave_t;

	typedef struct packed {
		logic signed [23:0] phase_step;
		logic        [24:0] duty;
		logic signed [15:0] amplitude;
		logic signed [15:0] offset;
		logic        [15:0] rise_step;
		logic        [15:0] fall_step;
		logic        [2:0]  waveform;
	} cfg_t;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767)
			r = 16'sh7FFF;
		else if (v < -18'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// Sine of angle t (cycle fraction * 2^32) in Q16. Quarter-wave fold,
	// Horner series to x^11 in Q30, round half up to Q16. Elaboration only.
	function automatic logic signed [17:0] sine_entry(input logic [63:0] t);
		logic [63:0] q;
		logic [63:0] f;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] r;
		logic signed [17:0] v;
		q = (t >> 30) & 64'd3;
		f = t & (Q30_ONE - 64'd1);
		if (q[0])
			f = Q30_ONE - f;
		x  = (f * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		h  = Q30_ONE - x2 / 64'd110;
		h  = Q30_ONE - ((x2 * h) >> 30) / 64'd72;
		h  = Q30_ONE - ((x2 * h) >> 30) / 64'd42;
		h  = Q30_ONE - ((x2 * h) >> 30) / 64'd20;
		h  = Q30_ONE - ((x2 * h) >> 30) / 64'd6;
		r  = (x * h) >> 30;
		v  = signed'(18'((r + 64'd8192) >> 14));
		return q[1] ? -v : v;
	endfunction

endpackage

`default_nettype wire

// File: hdl/rwg_cfg_regs.sv
// ----------------------------------------------------------------------------
// rwg_cfg_regs: configuration register file
// Seven registers written by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rwg_cfg_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             wr_en,
	input  wire logic [2:0]                       wr_index,
	input  wire logic [rwg_pkg::CFG_DATA_W-1:0]   wr_data,
	output rwg_pkg::cfg_t                         cfg
);

	rwg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_step <= '0;
			cfg_q.duty       <= 25'd16777216;
			cfg_q.amplitude  <= 16'sd4096;
			cfg_q.offset     <= '0;
			cfg_q.rise_step  <= 16'd4096;
			cfg_q.fall_step  <= 16'd4096;
			cfg_q.waveform   <= rwg_pkg::WF_STEP;
		end else if (wr_en) begin
			case (wr_index)
				rwg_pkg::REG_PHASE_STEP: cfg_q.phase_step <= signed'(wr_data[23:0]);
				rwg_pkg::REG_DUTY:       cfg_q.duty       <= wr_data[24:0];
				rwg_pkg::REG_AMPLITUDE:  cfg_q.amplitude  <= signed'(wr_data[15:0]);
				rwg_pkg::REG_OFFSET:     cfg_q.offset     <= signed'(wr_data[15:0]);
				rwg_pkg::REG_RISE_STEP:  cfg_q.rise_step  <= wr_data[15:0];
				rwg_pkg::REG_FALL_STEP:  cfg_q.fall_step  <= wr_data[15:0];
				rwg_pkg::REG_WAVEFORM:   cfg_q.waveform   <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hdl/rwg_sine_rom.sv
// ----------------------------------------------------------------------------
// rwg_sine_rom: synchronous sine ROM
// Contents are generated at elaboration; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rwg_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic signed [rwg_pkg::ROM_W-1:0]      rd_data
);

	logic signed [rwg_pkg::ROM_W-1:0] rom_w [DEPTH];
	logic signed [rwg_pkg::ROM_W-1:0] rd_data_q;

	for (genvar k = 0; k < DEPTH; k++) begin : g_rom
		localparam logic [63:0] ANGLE = (64'(k) << 32) / DEPTH;
		assign rom_w[k] = rwg_pkg::sine_entry(ANGLE);
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= rom_w[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: hdl/rwg_slew.sv
// ----------------------------------------------------------------------------
// rwg_slew: rise/fall rate limiter
// Moves the held level toward the target by at most one limit per update.
// ----------------------------------------------------------------------------
`default_nettype none

module rwg_slew (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               upd,
	input  wire logic signed [15:0] target,
	input  wire logic        [15:0] rise_step,
	input  wire logic        [15:0] fall_step,
	output logic signed [15:0]      level_next
);

	logic signed [15:0] level_q;
	logic signed [17:0] diff;
	logic signed [17:0] rise_x;
	logic signed [17:0] fall_x;

	assign diff   = 18'(target) - 18'(level_q);
	assign rise_x = signed'({2'b00, rise_step});
	assign fall_x = signed'({2'b00, fall_step});

	always_comb begin
		level_next = level_q;
		if (diff > 18'sd0) begin
			if (diff > rise_x)
				level_next = 16'(18'(level_q) + rise_x);
			else
				level_next = target;
		end else if (diff < 18'sd0) begin
			if (-diff > fall_x)
				level_next = 16'(18'(level_q) - fall_x);
			else
				level_next = target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			level_q <= '0;
		else if (upd)
			level_q <= level_next;
	end

endmodule

`default_nettype wire

// File: hdl/reference_waveform_generator_core.sv
// ----------------------------------------------------------------------------
// reference_waveform_generator_core: phase accumulator waveform generator
// Step, slew-limited step, constant, sine and zero reference waveforms.
// ----------------------------------------------------------------------------
// Usage
//  - Tick channel (tick_valid/tick_stall, payload tick): each accepted request
//    with tick = 1 advances the phase by phase_step and yields one sample;
//    a request with tick = 0 is consumed and yields nothing.
//  - Sample channel (sample_valid/sample_stall, payload sample, phase_now):
//    one request per tick, in order.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready,
//    one register write per cycle; write only while no ticks are in flight.
//  - Pipeline: four register stages (phase add, sine ROM read, multiply,
//    round/offset/saturate into the output register), the first one loading
//    at the accepting edge.
//  - Throughput: one tick per cycle while the pipeline does not stall; the
//    ROM is read whenever stage 2 loads, bubbles included.
//  - Stall: each stage holds only while it is full and the stage after it
//    holds, so bubbles close up; tick_stall rises only when all four stages
//    are full and sample_stall is high.
//  - Reset: registers take their documented defaults, phase and slew level
//    clear, the pipeline empties. The ROM is constant, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module reference_waveform_generator_core #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int PHASE_BITS       = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// tick channel
	input  wire logic                                tick_valid,
	output logic                                     tick_stall,
	input  wire logic                                tick,
	// sample channel
	output logic                                     sample_valid,
	input  wire logic                                sample_stall,
	output logic signed [rwg_pkg::SAMPLE_W-1:0]      sample,
	output logic [rwg_pkg::PHASE_OUT_W-1:0]          phase_now,
	// config channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [2:0]                          cfg_index,
	input  wire logic [rwg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW  = $clog2(SINE_TABLE_DEPTH);
	localparam int MW  = PHASE_BITS + AW + 1;               // index product width
	localparam int CW  = (PHASE_BITS > 25) ? PHASE_BITS : 25; // duty compare width
	localparam int PW  = 16 + rwg_pkg::ROM_W;               // sine product width

	rwg_pkg::cfg_t cfg;

	// stage enables: a stage loads when it is empty or the next one moves
	logic en1, en2, en3, en_o;
	logic acc;

	// stage 1: phase register doubles as the stage-1 payload
	logic                   v_s1;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [MW-1:0]          idx_prod;
	logic [AW-1:0]          rom_addr;
	logic signed [15:0]     rect;

	// stage 2
	logic                                 v_s2;
	logic signed [15:0]                   rect_s2;
	logic [rwg_pkg::PHASE_OUT_W-1:0]      phase_s2;
	logic signed [rwg_pkg::ROM_W-1:0]     rom_s2;
	logic signed [15:0]                   slew_next;
	logic                                 slew_upd;
	logic signed [15:0]                   base;

	// stage 3
	logic                                 v_s3;
	logic signed [PW-1:0]                 prod_s3;
	logic signed [15:0]                   base_s3;
	logic [rwg_pkg::PHASE_OUT_W-1:0]      phase_s3;
	logic signed [17:0]                   sine_rnd;
	logic signed [15:0]                   sample_d;

	// output register
	logic                                 out_valid_q;
	logic signed [15:0]                   sample_q;
	logic [rwg_pkg::PHASE_OUT_W-1:0]      phase_now_q;

	assign en_o       = !out_valid_q || !sample_stall;
	assign en3        = !v_s3 || en_o;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign tick_stall = !en1;
	assign acc        = tick_valid && en1;

	assign cfg_ready = 1'b1;

	rwg_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// ---- stage 1: phase accumulate, wraps modulo 2^PHASE_BITS ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			phase_q <= '0;
		end else begin
			if (en1)
				v_s1 <= acc && tick;
			if (acc && tick)
				phase_q <= phase_q + PHASE_BITS'(cfg.phase_step);
		end
	end

	// sine index = floor(phase * depth / 2^PHASE_BITS), always below depth
	assign idx_prod = MW'(phase_q) * MW'(SINE_TABLE_DEPTH);
	assign rom_addr = idx_prod[PHASE_BITS +: AW];

	// rectangle: high while phase is below duty
	assign rect = (CW'(cfg.duty) > CW'(phase_q))
		? rwg_pkg::sat16(18'(cfg.amplitude) + 18'(cfg.offset))
		: cfg.offset;

	rwg_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk     (clk),
		.rd_en   (en2),
		.rd_addr (rom_addr),
		.rd_data (rom_s2)
	);

	// ---- stage 2: slew limiter and waveform select ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			rect_s2  <= rect;
			phase_s2 <= rwg_pkg::PHASE_OUT_W'(phase_q);
		end
	end

	assign slew_upd = v_s2 && en3 && (cfg.waveform == rwg_pkg::WF_SLEW);

	rwg_slew u_slew (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (slew_upd),
		.target     (rect_s2),
		.rise_step  (cfg.rise_step),
		.fall_step  (cfg.fall_step),
		.level_next (slew_next)
	);

	always_comb begin
		case (cfg.waveform)
			rwg_pkg::WF_STEP:  base = rect_s2;
			rwg_pkg::WF_SLEW:  base = slew_next;
			rwg_pkg::WF_CONST: base = cfg.amplitude;
			default:           base = '0;   // zero and unused codes; sine uses prod
		endcase
	end

	// ---- stage 3: sine product ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			prod_s3  <= PW'(cfg.amplitude) * PW'(rom_s2);
			base_s3  <= base;
			phase_s3 <= phase_s2;
		end
	end

	// round half up by 16 bits, add offset, saturate
	assign sine_rnd = 18'((prod_s3 + PW'(32768)) >>> 16);
	assign sample_d = (cfg.waveform == rwg_pkg::WF_SINE)
		? rwg_pkg::sat16(sine_rnd + 18'(cfg.offset))
		: base_s3;

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en_o)
			out_valid_q <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			sample_q    <= sample_d;
			phase_now_q <= phase_s3;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = sample_q;
	assign phase_now    = phase_now_q;

	// ---- assertions ----
	a_tick_enters: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && !tick_stall && tick |=> v_s1)
		else $error("accepted tick did not enter stage 1");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> (v_s1 && v_s2 && v_s3 && out_valid_q && sample_stall))
		else $error("input stalled with a free pipeline slot");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !en3 |=> v_s2 && $stable(rect_s2) && $stable(phase_s2))
		else $error("stage 2 lost its request while blocked");

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(tick_valid && !tick_stall && tick) |=> $stable(phase_q))
		else $error("phase moved without a tick");

endmodule

`default_nettype wire
